// ===== rtl/lodc_pkg.sv =====
// Shared constants, action codes and the queued item type for the label overlap counter.
`timescale 1ns / 1ps
package lodc_pkg;

  localparam int DEF_LABEL_COUNT = 256;
  localparam int DEF_ROW_COUNT   = 512;
  localparam int DEF_COUNT_BITS  = 32;

  localparam int ROW_IN_BITS   = 9;
  localparam int ROW_MAX_BITS  = 10;
  localparam int LABEL_IN_BITS = 8;
  localparam int OUT_BITS      = 32;
  localparam int DICE_BITS     = 16;
  localparam int DIV_STEPS     = 16;

  localparam logic [DICE_BITS-1:0] Q15_ONE = 16'h8000;

  localparam logic [1:0] ACT_BIND  = 2'd0;
  localparam logic [1:0] ACT_VOXEL = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0]               action;
    logic [ROW_MAX_BITS-1:0]  row;
    logic [LABEL_IN_BITS-1:0] gt_label;
    logic [LABEL_IN_BITS-1:0] pred_label;
    logic                     row_ok;
    logic                     gt_ok;
    logic                     pred_ok;
  } item_t;

endpackage

// ===== rtl/lodc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module lodc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lodc_front.sv =====
// Front end: takes beats, checks row and label ranges, and queues them for the back end.
`timescale 1ns / 1ps
module lodc_front #(
  parameter int LABEL_COUNT = lodc_pkg::DEF_LABEL_COUNT,
  parameter int ROW_COUNT   = lodc_pkg::DEF_ROW_COUNT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          action,
  input  logic [lodc_pkg::ROW_IN_BITS-1:0]    row,
  input  logic [lodc_pkg::LABEL_IN_BITS-1:0]  gt_label,
  input  logic [lodc_pkg::LABEL_IN_BITS-1:0]  pred_label,
  input  logic                                clearing,
  output logic                                q_valid,
  output lodc_pkg::item_t                     q_item,
  input  logic                                q_pop
);

  lodc_pkg::item_t slots [2];
  lodc_pkg::item_t item_in;
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      cnt;
  logic            push;
  logic            pop;

  always_comb begin
    item_in.action     = action;
    item_in.row        = lodc_pkg::ROW_MAX_BITS'(row);
    item_in.gt_label   = gt_label;
    item_in.pred_label = pred_label;
    item_in.row_ok     = 32'(row) < 32'(ROW_COUNT);
    item_in.gt_ok      = 32'(gt_label) < 32'(LABEL_COUNT);
    item_in.pred_ok    = 32'(pred_label) < 32'(LABEL_COUNT);
  end

  assign busy    = (cnt == 2'd2) || clearing;
  assign push    = start && !busy;
  assign q_valid = (cnt != 2'd0);
  assign pop     = q_pop && q_valid;
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count out of range");
  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> cnt == $past(cnt) + 2'd1)
    else $error("queue did not grow on push");
`endif

endmodule

// ===== rtl/lodc_back.sv =====
// Back end: sequencer over the map and counter RAMs, query scoring and clearing sweep.
`timescale 1ns / 1ps
module lodc_back #(
  parameter int LABEL_COUNT = lodc_pkg::DEF_LABEL_COUNT,
  parameter int ROW_COUNT   = lodc_pkg::DEF_ROW_COUNT,
  parameter int COUNT_BITS  = lodc_pkg::DEF_COUNT_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  lodc_pkg::item_t                 q_item,
  output logic                            q_pop,
  output logic                            clearing,
  output logic                            valid,
  output logic [lodc_pkg::OUT_BITS-1:0]   truth_voxels,
  output logic [lodc_pkg::OUT_BITS-1:0]   guess_voxels,
  output logic [lodc_pkg::OUT_BITS-1:0]   overlap_voxels,
  output logic [lodc_pkg::DICE_BITS-1:0]  dice_score,
  output logic                            is_scored
);

  localparam int LW        = $clog2(LABEL_COUNT);
  localparam int RW        = $clog2(ROW_COUNT);
  localparam int MW        = RW + 1;
  localparam int CB        = COUNT_BITS;
  localparam int DW        = CB + 2;
  localparam int CLR_DEPTH = (LABEL_COUNT > ROW_COUNT) ? LABEL_COUNT : ROW_COUNT;
  localparam int CW        = $clog2(CLR_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_V1   = 4'd2;
  localparam logic [3:0] S_V2   = 4'd3;
  localparam logic [3:0] S_V3   = 4'd4;
  localparam logic [3:0] S_B1   = 4'd5;
  localparam logic [3:0] S_B2   = 4'd6;
  localparam logic [3:0] S_B3   = 4'd7;
  localparam logic [3:0] S_B4   = 4'd8;
  localparam logic [3:0] S_Q1   = 4'd9;
  localparam logic [3:0] S_Q2   = 4'd10;
  localparam logic [3:0] S_Q3   = 4'd11;
  localparam logic [3:0] S_DIV  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
    sat_inc = (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [lodc_pkg::OUT_BITS-1:0] clip(input logic [CB-1:0] v);
    logic [CB+31:0] wide;
    wide = (CB + 32)'(v);
    clip = (wide > (CB + 32)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : wide[31:0];
  endfunction

  logic [3:0]        state;
  logic [CW-1:0]     clr_cnt;
  lodc_pkg::item_t   it;
  logic              hit;
  logic [RW-1:0]     mrow;
  logic [LW-1:0]     og;
  logic [LW-1:0]     op;
  logic [LW-1:0]     glab;
  logic [LW-1:0]     plab;
  logic [CB-1:0]     gv;
  logic [CB-1:0]     pv;
  logic [CB-1:0]     ov;
  logic [CB:0]       den;
  logic [DW-1:0]     rem;
  logic [lodc_pkg::DICE_BITS-1:0] quo;
  logic [lodc_pkg::DICE_BITS-1:0] dice;
  logic              scored;
  logic [3:0]        step;

  logic              gm_we, pm_we, rl_we, gc_we, pc_we, oc_we;
  logic [LW-1:0]     gm_wa, pm_wa, gc_wa, pc_wa, gm_ra, pm_ra, gc_ra, pc_ra;
  logic [RW-1:0]     rl_wa, oc_wa, rl_ra, oc_ra;
  logic [MW-1:0]     gm_wd, pm_wd, gm_rd, pm_rd;
  logic [2*LW-1:0]   rl_wd, rl_rd;
  logic [CB-1:0]     gc_wd, pc_wd, oc_wd, gc_rd, pc_rd, oc_rd;

  logic [LW-1:0]     gl_in, pl_in, g_new, p_new;
  logic [RW-1:0]     r_in;
  logic              gm_valid, pm_valid;
  logic [RW-1:0]     gm_row, pm_row;
  logic              match;
  logic [CB-1:0]     gq, pq;
  logic [CB:0]       den_c;
  logic              scored_c, full_c;
  logic [DW-1:0]     rem_sh;
  logic              rem_ge;

  lodc_ram #(.WIDTH(MW), .DEPTH(LABEL_COUNT)) u_gmap (
    .clk(clk), .we(gm_we), .waddr(gm_wa), .wdata(gm_wd), .raddr(gm_ra), .rdata(gm_rd));
  lodc_ram #(.WIDTH(MW), .DEPTH(LABEL_COUNT)) u_pmap (
    .clk(clk), .we(pm_we), .waddr(pm_wa), .wdata(pm_wd), .raddr(pm_ra), .rdata(pm_rd));
  lodc_ram #(.WIDTH(2*LW), .DEPTH(ROW_COUNT)) u_rlab (
    .clk(clk), .we(rl_we), .waddr(rl_wa), .wdata(rl_wd), .raddr(rl_ra), .rdata(rl_rd));
  lodc_ram #(.WIDTH(CB), .DEPTH(LABEL_COUNT)) u_gcnt (
    .clk(clk), .we(gc_we), .waddr(gc_wa), .wdata(gc_wd), .raddr(gc_ra), .rdata(gc_rd));
  lodc_ram #(.WIDTH(CB), .DEPTH(LABEL_COUNT)) u_pcnt (
    .clk(clk), .we(pc_we), .waddr(pc_wa), .wdata(pc_wd), .raddr(pc_ra), .rdata(pc_rd));
  lodc_ram #(.WIDTH(CB), .DEPTH(ROW_COUNT)) u_ocnt (
    .clk(clk), .we(oc_we), .waddr(oc_wa), .wdata(oc_wd), .raddr(oc_ra), .rdata(oc_rd));

  assign gl_in    = it.gt_label[LW-1:0];
  assign pl_in    = it.pred_label[LW-1:0];
  assign r_in     = it.row[RW-1:0];
  assign g_new    = it.gt_ok ? gl_in : '0;
  assign p_new    = it.pred_ok ? pl_in : '0;
  assign gm_valid = gm_rd[MW-1];
  assign pm_valid = pm_rd[MW-1];
  assign gm_row   = gm_rd[RW-1:0];
  assign pm_row   = pm_rd[RW-1:0];
  assign match    = it.gt_ok && it.pred_ok && (gl_in != '0) && (pl_in != '0) &&
                    gm_valid && pm_valid && (gm_row == pm_row);

  assign gq       = (glab != '0) ? gc_rd : '0;
  assign pq       = (plab != '0) ? pc_rd : '0;
  assign den_c    = {1'b0, gq} + {1'b0, pq};
  assign scored_c = (glab != '0) && (plab != '0) && (den_c != '0);
  assign full_c   = {ov, 1'b0} >= den_c;
  assign rem_sh   = {rem[DW-2:0], 1'b0};
  assign rem_ge   = rem_sh >= {1'b0, den};

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign clearing = (state == S_INIT);

  always_comb begin
    gm_we = 1'b0; pm_we = 1'b0; rl_we = 1'b0; gc_we = 1'b0; pc_we = 1'b0; oc_we = 1'b0;
    gm_wa = '0; pm_wa = '0; gc_wa = '0; pc_wa = '0; rl_wa = '0; oc_wa = '0;
    gm_ra = '0; pm_ra = '0; gc_ra = '0; pc_ra = '0; rl_ra = '0; oc_ra = '0;
    gm_wd = '0; pm_wd = '0; rl_wd = '0; gc_wd = '0; pc_wd = '0; oc_wd = '0;
    case (state)
      S_INIT: begin
        gm_we = 32'(clr_cnt) < 32'(LABEL_COUNT);
        pm_we = gm_we;
        gc_we = gm_we;
        pc_we = gm_we;
        rl_we = 32'(clr_cnt) < 32'(ROW_COUNT);
        oc_we = rl_we;
        gm_wa = clr_cnt[LW-1:0];
        pm_wa = clr_cnt[LW-1:0];
        gc_wa = clr_cnt[LW-1:0];
        pc_wa = clr_cnt[LW-1:0];
        rl_wa = clr_cnt[RW-1:0];
        oc_wa = clr_cnt[RW-1:0];
      end
      S_V1: begin
        gm_ra = gl_in;
        pm_ra = pl_in;
        gc_ra = gl_in;
        pc_ra = pl_in;
      end
      S_V2: begin
        gc_we = it.gt_ok;
        gc_wa = gl_in;
        gc_wd = sat_inc(gc_rd);
        pc_we = it.pred_ok;
        pc_wa = pl_in;
        pc_wd = sat_inc(pc_rd);
        oc_ra = gm_row;
      end
      S_V3: begin
        oc_we = hit;
        oc_wa = mrow;
        oc_wd = sat_inc(oc_rd);
      end
      S_B1: begin
        rl_ra = r_in;
      end
      S_B2: begin
        gm_ra = rl_rd[2*LW-1:LW];
        pm_ra = rl_rd[LW-1:0];
      end
      S_B3: begin
        gm_we = (og != '0) && gm_valid && (gm_row == r_in);
        gm_wa = og;
        pm_we = (op != '0) && pm_valid && (pm_row == r_in);
        pm_wa = op;
      end
      S_B4: begin
        rl_we = 1'b1;
        rl_wa = r_in;
        rl_wd = {g_new, p_new};
        gm_we = (g_new != '0);
        gm_wa = g_new;
        gm_wd = {1'b1, r_in};
        pm_we = (p_new != '0);
        pm_wa = p_new;
        pm_wd = {1'b1, r_in};
      end
      S_Q1: begin
        rl_ra = r_in;
        oc_ra = r_in;
      end
      S_Q2: begin
        gc_ra = rl_rd[2*LW-1:LW];
        pc_ra = rl_rd[LW-1:0];
      end
      default: begin
        gm_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      clr_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_item.action)
              lodc_pkg::ACT_BIND:  state <= q_item.row_ok ? S_B1 : S_IDLE;
              lodc_pkg::ACT_VOXEL: state <= S_V1;
              lodc_pkg::ACT_QUERY: state <= q_item.row_ok ? S_Q1 : S_OUT;
              default: begin
                clr_cnt <= '0;
                state   <= S_INIT;
              end
            endcase
          end
        end
        S_INIT: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CW'(CLR_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_V1:  state <= S_V2;
        S_V2:  state <= S_V3;
        S_V3:  state <= S_IDLE;
        S_B1:  state <= S_B2;
        S_B2:  state <= S_B3;
        S_B3:  state <= S_B4;
        S_B4:  state <= S_IDLE;
        S_Q1:  state <= S_Q2;
        S_Q2:  state <= S_Q3;
        S_Q3: begin
          state <= (scored_c && !full_c) ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (step == 4'(lodc_pkg::DIV_STEPS - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT:   state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        it     <= q_item;
        gv     <= '0;
        pv     <= '0;
        ov     <= '0;
        dice   <= '0;
        scored <= 1'b0;
      end
      S_V2: begin
        hit  <= match;
        mrow <= gm_row;
      end
      S_B2: begin
        og <= rl_rd[2*LW-1:LW];
        op <= rl_rd[LW-1:0];
      end
      S_Q2: begin
        glab <= rl_rd[2*LW-1:LW];
        plab <= rl_rd[LW-1:0];
        ov   <= oc_rd;
      end
      S_Q3: begin
        gv     <= gq;
        pv     <= pq;
        den    <= den_c;
        scored <= scored_c;
        rem    <= DW'(ov);
        quo    <= '0;
        step   <= '0;
        dice   <= (scored_c && full_c) ? lodc_pkg::Q15_ONE : '0;
      end
      S_DIV: begin
        rem  <= rem_ge ? rem_sh - {1'b0, den} : rem_sh;
        quo  <= {quo[lodc_pkg::DICE_BITS-2:0], rem_ge};
        step <= step + 4'd1;
        if (step == 4'(lodc_pkg::DIV_STEPS - 1)) begin
          dice <= {quo[lodc_pkg::DICE_BITS-2:0], rem_ge};
        end
      end
      default: begin
        hit <= hit;
      end
    endcase
  end

  assign valid          = (state == S_OUT);
  assign truth_voxels   = clip(gv);
  assign guess_voxels   = clip(pv);
  assign overlap_voxels = clip(ov);
  assign dice_score     = dice;
  assign is_scored      = scored;

`ifndef SYNTHESIS
  a_dice_cap: assert property (@(posedge clk) disable iff (rst)
    valid |-> dice_score <= lodc_pkg::Q15_ONE)
    else $error("dice score above one");
  a_unscored_zero: assert property (@(posedge clk) disable iff (rst)
    valid && !is_scored |-> dice_score == '0)
    else $error("unscored row with nonzero dice");
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid)
    else $error("result strobe longer than one cycle");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_pop)
    else $error("item taken during clearing sweep");
`endif

endmodule

// ===== rtl/label_overlap_dice_counter_top.sv =====
// Top level of the label overlap Dice counter: front queue and back sequencer.
//
//   channel   handshake        payload
//   input     start / busy     action, row, gt_label, pred_label
//   result    valid (strobe)   truth_voxels, guess_voxels, overlap_voxels, dice_score, is_scored
//
// In the back end a voxel beat runs states V1-V3, a bind B1-B4, and a query Q1-Q3 and then
// a divide when the score is below one; a clear sweeps max(LABEL_COUNT, ROW_COUNT) addresses.
// After reset the RAMs are swept the same way with busy high.
// A two-beat queue takes input while the back end works; busy is high when it is full or while a sweep runs.
// The result strobe lasts one cycle and is never held off.
`timescale 1ns / 1ps
module label_overlap_dice_counter_top #(
  parameter int LABEL_COUNT = lodc_pkg::DEF_LABEL_COUNT,
  parameter int ROW_COUNT   = lodc_pkg::DEF_ROW_COUNT,
  parameter int COUNT_BITS  = lodc_pkg::DEF_COUNT_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          action,
  input  logic [lodc_pkg::ROW_IN_BITS-1:0]    row,
  input  logic [lodc_pkg::LABEL_IN_BITS-1:0]  gt_label,
  input  logic [lodc_pkg::LABEL_IN_BITS-1:0]  pred_label,
  output logic                                valid,
  output logic [lodc_pkg::OUT_BITS-1:0]       truth_voxels,
  output logic [lodc_pkg::OUT_BITS-1:0]       guess_voxels,
  output logic [lodc_pkg::OUT_BITS-1:0]       overlap_voxels,
  output logic [lodc_pkg::DICE_BITS-1:0]      dice_score,
  output logic                                is_scored
);

  logic            q_valid;
  logic            q_pop;
  logic            clearing;
  lodc_pkg::item_t q_item;

  lodc_front #(
    .LABEL_COUNT(LABEL_COUNT),
    .ROW_COUNT(ROW_COUNT)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .row(row),
    .gt_label(gt_label),
    .pred_label(pred_label),
    .clearing(clearing),
    .q_valid(q_valid),
    .q_item(q_item),
    .q_pop(q_pop)
  );

  lodc_back #(
    .LABEL_COUNT(LABEL_COUNT),
    .ROW_COUNT(ROW_COUNT),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_item(q_item),
    .q_pop(q_pop),
    .clearing(clearing),
    .valid(valid),
    .truth_voxels(truth_voxels),
    .guess_voxels(guess_voxels),
    .overlap_voxels(overlap_voxels),
    .dice_score(dice_score),
    .is_scored(is_scored)
  );

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the label overlap Dice counter: queued driver, predictor and result check.
`timescale 1ns / 1ps
module tb_top;

  localparam int NLAB = 256;
  localparam int NROW = 512;
  localparam logic [63:0] CNT_TOP = 64'hFFFF_FFFF;
  localparam int WATCHDOG = 20000;
  localparam int TAIL = 700;

  typedef struct {
    logic [1:0] action;
    logic [8:0] row;
    logic [7:0] gt_label;
    logic [7:0] pred_label;
  } beat_t;

  typedef struct {
    logic [31:0] truth_voxels;
    logic [31:0] guess_voxels;
    logic [31:0] overlap_voxels;
    logic [15:0] dice_score;
    logic        is_scored;
  } score_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [1:0] action = lodc_pkg::ACT_BIND;
  logic [8:0] row = 0;
  logic [7:0] gt_label = 0;
  logic [7:0] pred_label = 0;
  logic busy, valid, is_scored;
  logic [31:0] truth_voxels, guess_voxels, overlap_voxels;
  logic [15:0] dice_score;

  beat_t  pending_q[$];
  score_t query_results_q[$];
  int     errors = 0;
  logic   beat_taken = 0;
  logic   stim_done = 0;
  int     idle_left = 0;
  int     quiet_cycles = 0;

  bit          gt_valid[NLAB];
  logic [9:0]  gt_row[NLAB];
  bit          pr_valid[NLAB];
  logic [9:0]  pr_row[NLAB];
  logic [7:0]  row_gt[NROW];
  logic [7:0]  row_pr[NROW];
  logic [63:0] gt_cnt[NLAB];
  logic [63:0] pr_cnt[NLAB];
  logic [63:0] ov_cnt[NROW];

  label_overlap_dice_counter_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action), .row(row),
    .gt_label(gt_label), .pred_label(pred_label), .valid(valid),
    .truth_voxels(truth_voxels), .guess_voxels(guess_voxels),
    .overlap_voxels(overlap_voxels), .dice_score(dice_score), .is_scored(is_scored)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] bump(logic [63:0] v);
    return (v >= CNT_TOP) ? CNT_TOP : v + 1;
  endfunction

  task automatic wipe_counts();
    for (int i = 0; i < NLAB; i++) begin
      gt_valid[i] = 0; gt_row[i] = 0; pr_valid[i] = 0; pr_row[i] = 0;
      gt_cnt[i] = 0; pr_cnt[i] = 0;
    end
    for (int i = 0; i < NROW; i++) begin
      row_gt[i] = 0; row_pr[i] = 0; ov_cnt[i] = 0;
    end
  endtask

  task automatic tally_beat(beat_t b);
    int r, g, p, og, op;
    logic [63:0] gc, pc, oc, den, dice;
    score_t s;
    r = b.row; g = b.gt_label; p = b.pred_label;
    case (b.action)
      lodc_pkg::ACT_BIND: begin
        og = row_gt[r]; op = row_pr[r];
        if (og != 0 && gt_valid[og] && gt_row[og] == r) gt_valid[og] = 0;
        if (op != 0 && pr_valid[op] && pr_row[op] == r) pr_valid[op] = 0;
        row_gt[r] = 8'(g); row_pr[r] = 8'(p);
        if (g != 0) begin
          gt_valid[g] = 1; gt_row[g] = 10'(r);
        end
        if (p != 0) begin
          pr_valid[p] = 1; pr_row[p] = 10'(r);
        end
      end
      lodc_pkg::ACT_VOXEL: begin
        gt_cnt[g] = bump(gt_cnt[g]);
        pr_cnt[p] = bump(pr_cnt[p]);
        if (g != 0 && p != 0 && gt_valid[g] && pr_valid[p] && gt_row[g] == pr_row[p])
          ov_cnt[gt_row[g]] = bump(ov_cnt[gt_row[g]]);
      end
      lodc_pkg::ACT_QUERY: begin
        gc = (row_gt[r] != 0) ? gt_cnt[row_gt[r]] : 0;
        pc = (row_pr[r] != 0) ? pr_cnt[row_pr[r]] : 0;
        oc = ov_cnt[r];
        den = gc + pc;
        dice = 0;
        s.is_scored = 0;
        if (row_gt[r] != 0 && row_pr[r] != 0 && den > 0) begin
          s.is_scored = 1;
          dice = (oc * 2 >= den) ? 64'd32768 : (oc << 16) / den;
        end
        s.truth_voxels = (gc > CNT_TOP) ? CNT_TOP[31:0] : gc[31:0];
        s.guess_voxels = (pc > CNT_TOP) ? CNT_TOP[31:0] : pc[31:0];
        s.overlap_voxels = (oc > CNT_TOP) ? CNT_TOP[31:0] : oc[31:0];
        s.dice_score = dice[15:0];
        query_results_q = {query_results_q, s};
      end
      default: wipe_counts();
    endcase
  endtask

  // check results, then take the beat presented at this edge
  always @(posedge clk) begin
    score_t e;
    beat_t b;
    bit seen;
    seen = 0;
    if (!rst && valid) begin
      seen = 1;
      if (query_results_q.size() == 0) begin
        $display("%0t: result with none pending: gt %0d pred %0d ov %0d dice %0d sc %0b",
                 $time, truth_voxels, guess_voxels, overlap_voxels, dice_score, is_scored);
        errors++;
      end else begin
        e = query_results_q.pop_front();
        if (e.truth_voxels !== truth_voxels) begin
          $display("%0t: truth_voxels exp %0d got %0d", $time, e.truth_voxels,
                   truth_voxels);
          errors++;
        end
        if (e.guess_voxels !== guess_voxels) begin
          $display("%0t: guess_voxels exp %0d got %0d", $time, e.guess_voxels,
                   guess_voxels);
          errors++;
        end
        if (e.overlap_voxels !== overlap_voxels) begin
          $display("%0t: overlap_voxels exp %0d got %0d", $time, e.overlap_voxels,
                   overlap_voxels);
          errors++;
        end
        if (e.dice_score !== dice_score) begin
          $display("%0t: dice_score exp %0d got %0d", $time, e.dice_score, dice_score);
          errors++;
        end
        if (e.is_scored !== is_scored) begin
          $display("%0t: is_scored exp %0b got %0b", $time, e.is_scored, is_scored);
          errors++;
        end
      end
    end
    if (!rst && start && busy === 1'b0) begin
      b.action = action; b.row = row; b.gt_label = gt_label; b.pred_label = pred_label;
      tally_beat(b);
      beat_taken <= 1;
      seen = 1;
    end else begin
      beat_taken <= 0;
    end
    quiet_cycles <= seen ? 0 : quiet_cycles + 1;
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // present the next beat at the falling edge once the current one is taken
  always @(negedge clk) begin
    beat_t b;
    if (!rst && (!start || beat_taken)) begin
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 0;
      end else if (pending_q.size() > 0) begin
        b = pending_q.pop_front();
        action <= b.action; row <= b.row; gt_label <= b.gt_label; pred_label <= b.pred_label;
        start <= 1;
        if (pending_q.size() > 200 && $urandom_range(0, 5) == 0)
          idle_left <= $urandom_range(1, 4);
      end else begin
        start <= 0;
      end
    end
  end

  task automatic add(logic [1:0] a, int r, int g, int p);
    beat_t b;
    b.action = a; b.row = 9'(r); b.gt_label = 8'(g); b.pred_label = 8'(p);
    pending_q = {pending_q, b};
  endtask

  function automatic int pick_label();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 0;
    if (k < 8) return $urandom_range(1, 12);
    return $urandom_range(0, 255);
  endfunction

  initial begin
    int k, r;
    wipe_counts();
    add(lodc_pkg::ACT_BIND, 0, 255, 255);
    add(lodc_pkg::ACT_BIND, 511, 1, 1);
    add(lodc_pkg::ACT_VOXEL, 0, 0, 0);
    add(lodc_pkg::ACT_VOXEL, 0, 255, 255);
    add(lodc_pkg::ACT_VOXEL, 0, 1, 1);
    add(lodc_pkg::ACT_VOXEL, 0, 255, 1);
    add(lodc_pkg::ACT_VOXEL, 511, 1, 255);
    add(lodc_pkg::ACT_QUERY, 0, 0, 0);
    add(lodc_pkg::ACT_QUERY, 511, 0, 0);
    add(lodc_pkg::ACT_BIND, 5, 1, 2);
    add(lodc_pkg::ACT_VOXEL, 0, 1, 2);
    add(lodc_pkg::ACT_VOXEL, 0, 1, 1);
    add(lodc_pkg::ACT_QUERY, 5, 0, 0);
    add(lodc_pkg::ACT_QUERY, 511, 0, 0);
    add(lodc_pkg::ACT_BIND, 5, 0, 2);
    add(lodc_pkg::ACT_QUERY, 5, 0, 0);
    add(lodc_pkg::ACT_QUERY, 7, 255, 255);
    add(lodc_pkg::ACT_BIND, 0, 3, 4);
    add(lodc_pkg::ACT_QUERY, 0, 0, 0);
    add(lodc_pkg::ACT_CLEAR, 511, 255, 255);
    add(lodc_pkg::ACT_QUERY, 0, 0, 0);
    add(lodc_pkg::ACT_VOXEL, 0, 255, 255);
    add(lodc_pkg::ACT_QUERY, 0, 0, 0);
    for (int i = 0; i < 1750; i++) begin
      k = $urandom_range(0, 999);
      r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 15);
      if (k < 3)
        add(lodc_pkg::ACT_CLEAR, $urandom_range(0, 511), $urandom_range(0, 255),
            $urandom_range(0, 255));
      else if (k < 50)
        add(lodc_pkg::ACT_BIND, r, pick_label(), pick_label());
      else if (k < 130)
        add(lodc_pkg::ACT_QUERY, r, $urandom_range(0, 255), $urandom_range(0, 255));
      else
        add(lodc_pkg::ACT_VOXEL, $urandom_range(0, 511), pick_label(), pick_label());
    end
    repeat (7) @(posedge clk);
    @(negedge clk) rst = 0;
    wait (pending_q.size() == 0 && start == 0);
    wait (query_results_q.size() == 0);
    repeat (TAIL) @(posedge clk);
    if (errors == 0 && query_results_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
